// ===== rtl/rmq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_pkg: shared types and constants
// Widths of the fixed-point datapath, the component code and the sideband
// records that travel with each beat through the pipeline.
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int DATA_W = 16;              // Q2.(DATA_W-2) samples
  localparam int FRAC_W = DATA_W - 2;
  localparam int TR_W   = DATA_W + 2;      // three-term sum
  localparam int PAIR_W = DATA_W + 1;      // two-term sum
  localparam int SUM_W  = DATA_W + 1;      // lane numerator, signed
  localparam int MAG_W  = DATA_W + 1;      // lane numerator magnitude
  localparam int ARG_W  = DATA_W + 3;      // root argument, signed
  localparam int ROOT_W = DATA_W;
  localparam int RAD_W  = 2 * ROOT_W;      // radicand
  localparam int NUM_W  = 2 * DATA_W;      // dividend
  localparam int DIV_W  = DATA_W + 1;      // divisor 2*s
  localparam int QUO_W  = NUM_W - FRAC_W / 2 - 1;
  localparam int CMP_W  = DIV_W + QUO_W;
  localparam int LANES  = 3;

  localparam logic signed [ARG_W-1:0] ONE_ARG = ARG_W'(2 ** FRAC_W);
  localparam logic [QUO_W-1:0] POS_LIM = (QUO_W'(1) << (DATA_W - 1)) - QUO_W'(1);
  localparam logic [QUO_W-1:0] NEG_LIM = QUO_W'(1) << (DATA_W - 1);

  // component that receives half the root
  typedef enum logic [1:0] {
    COMP_X = 2'd0,
    COMP_Y = 2'd1,
    COMP_Z = 2'd2,
    COMP_W = 2'd3
  } comp_t;

  typedef struct packed {
    comp_t                        sel;
    logic                         neg_arg;
    logic [LANES-1:0]             neg;
    logic [LANES-1:0][MAG_W-1:0]  mag;
  } root_side_t;

  typedef struct packed {
    comp_t             sel;
    logic              neg_arg;
    logic [LANES-1:0]  neg;
    logic              zero;
    logic [DATA_W-1:0] half;
  } div_side_t;

endpackage

// ===== rtl/rmq_prep.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_prep: front end
// Two stages: sums, trace and axis pick, then root argument, radicand and
// lane numerators in sign-magnitude form.
// ----------------------------------------------------------------------------
module rmq_prep (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic signed [rmq_pkg::DATA_W-1:0] e0,
  input  logic signed [rmq_pkg::DATA_W-1:0] e1,
  input  logic signed [rmq_pkg::DATA_W-1:0] e2,
  input  logic signed [rmq_pkg::DATA_W-1:0] e4,
  input  logic signed [rmq_pkg::DATA_W-1:0] e5,
  input  logic signed [rmq_pkg::DATA_W-1:0] e6,
  input  logic signed [rmq_pkg::DATA_W-1:0] e8,
  input  logic signed [rmq_pkg::DATA_W-1:0] e9,
  input  logic signed [rmq_pkg::DATA_W-1:0] e10,
  output logic                              out_valid,
  output logic [rmq_pkg::RAD_W-1:0]         out_rad,
  output rmq_pkg::root_side_t               out_side
);

  // stage A
  logic                              va_r;
  logic signed [rmq_pkg::DATA_W-1:0] e0_r, e5_r, e10_r;
  logic signed [rmq_pkg::TR_W-1:0]   tr_r;
  logic signed [rmq_pkg::PAIR_W-1:0] p510_r, p100_r, p05_r;
  logic signed [rmq_pkg::SUM_W-1:0]  a14_r, a28_r, a69_r, dx_r, dy_r, dz_r;
  rmq_pkg::comp_t                    ia_r;
  rmq_pkg::comp_t                    ia_nxt;
  logic                              c50;

  always_comb begin
    c50 = e5 > e0;
    if (c50 ? (e10 > e5) : (e10 > e0)) begin
      ia_nxt = rmq_pkg::COMP_Z;
    end else if (c50) begin
      ia_nxt = rmq_pkg::COMP_Y;
    end else begin
      ia_nxt = rmq_pkg::COMP_X;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else begin
      va_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    e0_r   <= e0;
    e5_r   <= e5;
    e10_r  <= e10;
    tr_r   <= rmq_pkg::TR_W'(e0) + rmq_pkg::TR_W'(e5) + rmq_pkg::TR_W'(e10);
    p510_r <= rmq_pkg::PAIR_W'(e5) + rmq_pkg::PAIR_W'(e10);
    p100_r <= rmq_pkg::PAIR_W'(e10) + rmq_pkg::PAIR_W'(e0);
    p05_r  <= rmq_pkg::PAIR_W'(e0) + rmq_pkg::PAIR_W'(e5);
    a14_r  <= rmq_pkg::SUM_W'(e1) + rmq_pkg::SUM_W'(e4);
    a28_r  <= rmq_pkg::SUM_W'(e2) + rmq_pkg::SUM_W'(e8);
    a69_r  <= rmq_pkg::SUM_W'(e6) + rmq_pkg::SUM_W'(e9);
    dx_r   <= rmq_pkg::SUM_W'(e9) - rmq_pkg::SUM_W'(e6);
    dy_r   <= rmq_pkg::SUM_W'(e2) - rmq_pkg::SUM_W'(e8);
    dz_r   <= rmq_pkg::SUM_W'(e4) - rmq_pkg::SUM_W'(e1);
    ia_r   <= ia_nxt;
  end

  // stage B
  logic                             vb_r;
  logic [rmq_pkg::RAD_W-1:0]        rad_r, rad_nxt;
  rmq_pkg::root_side_t              side_r, side_nxt;
  logic signed [rmq_pkg::ARG_W-1:0] arg;
  logic signed [rmq_pkg::SUM_W-1:0] lane [rmq_pkg::LANES];
  logic                             pos;

  always_comb begin
    pos = tr_r > 0;
    if (pos) begin
      arg = rmq_pkg::ARG_W'(tr_r) + rmq_pkg::ONE_ARG;
      side_nxt.sel = rmq_pkg::COMP_W;
    end else begin
      side_nxt.sel = ia_r;
      case (ia_r)
        rmq_pkg::COMP_Y: arg = rmq_pkg::ARG_W'(e5_r) - rmq_pkg::ARG_W'(p100_r)
                               + rmq_pkg::ONE_ARG;
        rmq_pkg::COMP_Z: arg = rmq_pkg::ARG_W'(e10_r) - rmq_pkg::ARG_W'(p05_r)
                               + rmq_pkg::ONE_ARG;
        default:         arg = rmq_pkg::ARG_W'(e0_r) - rmq_pkg::ARG_W'(p510_r)
                               + rmq_pkg::ONE_ARG;
      endcase
    end
    // lanes hold the three components that are not the half root, in order
    unique case (side_nxt.sel)
      rmq_pkg::COMP_X: begin lane[0] = a14_r; lane[1] = a28_r; lane[2] = dx_r; end
      rmq_pkg::COMP_Y: begin lane[0] = a14_r; lane[1] = a69_r; lane[2] = dy_r; end
      rmq_pkg::COMP_Z: begin lane[0] = a28_r; lane[1] = a69_r; lane[2] = dz_r; end
      default:         begin lane[0] = dx_r;  lane[1] = dy_r;  lane[2] = dz_r; end
    endcase
    for (int l = 0; l < rmq_pkg::LANES; l++) begin
      side_nxt.neg[l] = lane[l][rmq_pkg::SUM_W-1];
      side_nxt.mag[l] = side_nxt.neg[l] ? rmq_pkg::MAG_W'(-lane[l])
                                        : rmq_pkg::MAG_W'(lane[l]);
    end
    side_nxt.neg_arg = arg[rmq_pkg::ARG_W-1];
    rad_nxt = side_nxt.neg_arg ? '0
            : (rmq_pkg::RAD_W'(arg[rmq_pkg::DATA_W:0]) << rmq_pkg::FRAC_W);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    side_r <= side_nxt;
  end

  assign out_valid = vb_r;
  assign out_rad   = rad_r;
  assign out_side  = side_r;

endmodule

// ===== rtl/rmq_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_sqrt: pipelined integer square root
// One result bit per stage, ROOT_W stages, sideband carried alongside.
// ----------------------------------------------------------------------------
module rmq_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [rmq_pkg::RAD_W-1:0]  in_rad,
  input  rmq_pkg::root_side_t        in_side,
  output logic                       out_valid,
  output logic [rmq_pkg::ROOT_W-1:0] out_root,
  output rmq_pkg::root_side_t        out_side
);

  localparam int N = rmq_pkg::ROOT_W;

  logic                      valid_r [N];
  logic [rmq_pkg::RAD_W-1:0] v_r     [N];
  logic [rmq_pkg::RAD_W-1:0] res_r   [N];
  rmq_pkg::root_side_t       side_r  [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam logic [rmq_pkg::RAD_W-1:0] BIT = rmq_pkg::RAD_W'(1) << (2 * (N - 1 - k));
    logic                      vld_src;
    logic [rmq_pkg::RAD_W-1:0] v_src, res_src, v_nxt, res_nxt;
    logic [rmq_pkg::RAD_W:0]   trial;
    rmq_pkg::root_side_t       side_src;

    if (k == 0) begin : g_head
      assign vld_src  = in_valid;
      assign v_src    = in_rad;
      assign res_src  = '0;
      assign side_src = in_side;
    end else begin : g_body
      assign vld_src  = valid_r[k-1];
      assign v_src    = v_r[k-1];
      assign res_src  = res_r[k-1];
      assign side_src = side_r[k-1];
    end

    always_comb begin
      trial = {1'b0, res_src} + {1'b0, BIT};
      if ({1'b0, v_src} >= trial) begin
        v_nxt   = v_src - trial[rmq_pkg::RAD_W-1:0];
        res_nxt = (res_src >> 1) + BIT;
      end else begin
        v_nxt   = v_src;
        res_nxt = res_src >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else begin
        valid_r[k] <= vld_src;
      end
    end

    always_ff @(posedge clk) begin
      v_r[k]    <= v_nxt;
      res_r[k]  <= res_nxt;
      side_r[k] <= side_src;
    end
  end

  assign out_valid = valid_r[N-1];
  assign out_root  = res_r[N-1][rmq_pkg::ROOT_W-1:0];
  assign out_side  = side_r[N-1];

  // remainder of an integer root never exceeds twice the root
  a_root_rem: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[N-1] |-> ({1'b0, v_r[N-1]} <= {res_r[N-1], 1'b0}))
    else $error("sqrt remainder out of range");

endmodule

// ===== rtl/rmq_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_div: three-lane pipelined divider
// Forms (|d|*2^F + s) / 2s per lane, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rmq_div (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            in_valid,
  input  logic [rmq_pkg::ROOT_W-1:0]                      in_root,
  input  rmq_pkg::root_side_t                             in_side,
  output logic                                            out_valid,
  output logic [rmq_pkg::LANES-1:0][rmq_pkg::QUO_W-1:0]   out_quo,
  output rmq_pkg::div_side_t                              out_side
);

  localparam int N = rmq_pkg::QUO_W;

  // setup stage
  logic                                          v0_r;
  logic [rmq_pkg::LANES-1:0][rmq_pkg::NUM_W-1:0] n0_r;
  logic [rmq_pkg::DIV_W-1:0]                     d0_r;
  rmq_pkg::div_side_t                            s0_r, s0_nxt;
  logic [rmq_pkg::LANES-1:0][rmq_pkg::NUM_W-1:0] n0_nxt;
  logic [rmq_pkg::ROOT_W:0]                      root_p1;

  always_comb begin
    root_p1         = {1'b0, in_root} + (rmq_pkg::ROOT_W + 1)'(1);
    s0_nxt.sel      = in_side.sel;
    s0_nxt.neg_arg  = in_side.neg_arg;
    s0_nxt.neg      = in_side.neg;
    s0_nxt.zero     = in_root == '0;
    s0_nxt.half     = rmq_pkg::DATA_W'(root_p1 >> 1);
    for (int l = 0; l < rmq_pkg::LANES; l++) begin
      n0_nxt[l] = (rmq_pkg::NUM_W'(in_side.mag[l]) << rmq_pkg::FRAC_W)
                + rmq_pkg::NUM_W'(in_root);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    n0_r <= n0_nxt;
    d0_r <= {in_root, 1'b0};
    s0_r <= s0_nxt;
  end

  logic                                          valid_r [N];
  logic [rmq_pkg::LANES-1:0][rmq_pkg::NUM_W-1:0] rem_r   [N];
  logic [rmq_pkg::LANES-1:0][rmq_pkg::QUO_W-1:0] quo_r   [N];
  logic [rmq_pkg::DIV_W-1:0]                     d_r     [N];
  rmq_pkg::div_side_t                            side_r  [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam int B = N - 1 - k;
    logic                                          vld_src;
    logic [rmq_pkg::LANES-1:0][rmq_pkg::NUM_W-1:0] rem_src, rem_nxt;
    logic [rmq_pkg::LANES-1:0][rmq_pkg::QUO_W-1:0] quo_src, quo_nxt;
    logic [rmq_pkg::DIV_W-1:0]                     d_src;
    rmq_pkg::div_side_t                            side_src;
    logic [rmq_pkg::CMP_W-1:0]                     trial;

    if (k == 0) begin : g_head
      assign vld_src  = v0_r;
      assign rem_src  = n0_r;
      assign quo_src  = '0;
      assign d_src    = d0_r;
      assign side_src = s0_r;
    end else begin : g_body
      assign vld_src  = valid_r[k-1];
      assign rem_src  = rem_r[k-1];
      assign quo_src  = quo_r[k-1];
      assign d_src    = d_r[k-1];
      assign side_src = side_r[k-1];
    end

    always_comb begin
      trial = rmq_pkg::CMP_W'(d_src) << B;
      for (int l = 0; l < rmq_pkg::LANES; l++) begin
        if (rmq_pkg::CMP_W'(rem_src[l]) >= trial) begin
          rem_nxt[l] = rem_src[l] - trial[rmq_pkg::NUM_W-1:0];
          quo_nxt[l] = quo_src[l] | (rmq_pkg::QUO_W'(1) << B);
        end else begin
          rem_nxt[l] = rem_src[l];
          quo_nxt[l] = quo_src[l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else begin
        valid_r[k] <= vld_src;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k]  <= rem_nxt;
      quo_r[k]  <= quo_nxt;
      d_r[k]    <= d_src;
      side_r[k] <= side_src;
    end
  end

  assign out_valid = valid_r[N-1];
  assign out_quo   = quo_r[N-1];
  assign out_side  = side_r[N-1];

  // a finished division leaves a remainder below the divisor
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r[N-1] && !side_r[N-1].zero) |->
      (rem_r[N-1][0] < rmq_pkg::NUM_W'(d_r[N-1]) &&
       rem_r[N-1][1] < rmq_pkg::NUM_W'(d_r[N-1]) &&
       rem_r[N-1][2] < rmq_pkg::NUM_W'(d_r[N-1])))
    else $error("divider remainder not below divisor");

endmodule

// ===== rtl/rotation_matrix_to_quaternion.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion: 3x3 rotation to quaternion, fixed point
// Converts the upper-left 3x3 of a flat 4x4 rotation matrix in Q2.14 to
// a quaternion (x, y, z, w) in Q2.14 with saturation and an overflow flag.
//
// Usage:
//   - Input beat: drive the nine in_elem_* ports and pulse start. A beat is
//     taken on every edge with start high and busy low; busy stays low, so
//     a new matrix may enter every cycle.
//   - Result beat: out_valid is high for one cycle with out_quat_* and
//     out_overflow_flag. The receiver must take it; there is no back
//     pressure and none is needed.
//   - Throughput: one matrix per cycle. From accept to out_valid a beat
//     passes the front-end stages, the square-root pipeline (one root
//     bit per stage), the divider setup stage, the three-lane divider
//     (one quotient bit per stage) and the output register.
//   - Reset (rst_n low, synchronous) clears every valid bit; beats in
//     flight are dropped and no strobe follows.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [rmq_pkg::DATA_W-1:0] in_elem_0,
  input  logic signed [rmq_pkg::DATA_W-1:0] in_elem_1,
  input  logic signed [rmq_pkg::DATA_W-1:0] in_elem_2,
  input  logic signed [rmq_pkg::DATA_W-1:0] in_elem_4,
  input  logic signed [rmq_pkg::DATA_W-1:0] in_elem_5,
  input  logic signed [rmq_pkg::DATA_W-1:0] in_elem_6,
  input  logic signed [rmq_pkg::DATA_W-1:0] in_elem_8,
  input  logic signed [rmq_pkg::DATA_W-1:0] in_elem_9,
  input  logic signed [rmq_pkg::DATA_W-1:0] in_elem_10,
  output logic                              out_valid,
  output logic signed [rmq_pkg::DATA_W-1:0] out_quat_x,
  output logic signed [rmq_pkg::DATA_W-1:0] out_quat_y,
  output logic signed [rmq_pkg::DATA_W-1:0] out_quat_z,
  output logic signed [rmq_pkg::DATA_W-1:0] out_quat_w,
  output logic                              out_overflow_flag
);

  // fully pipelined: never holds off a beat
  assign busy = 1'b0;

  logic                      pr_valid;
  logic [rmq_pkg::RAD_W-1:0] pr_rad;
  rmq_pkg::root_side_t       pr_side;

  rmq_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start && !busy),
    .e0        (in_elem_0),
    .e1        (in_elem_1),
    .e2        (in_elem_2),
    .e4        (in_elem_4),
    .e5        (in_elem_5),
    .e6        (in_elem_6),
    .e8        (in_elem_8),
    .e9        (in_elem_9),
    .e10       (in_elem_10),
    .out_valid (pr_valid),
    .out_rad   (pr_rad),
    .out_side  (pr_side)
  );

  logic                       sq_valid;
  logic [rmq_pkg::ROOT_W-1:0] sq_root;
  rmq_pkg::root_side_t        sq_side;

  rmq_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pr_valid),
    .in_rad    (pr_rad),
    .in_side   (pr_side),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  logic                                          dv_valid;
  logic [rmq_pkg::LANES-1:0][rmq_pkg::QUO_W-1:0] dv_quo;
  rmq_pkg::div_side_t                            dv_side;

  rmq_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sq_valid),
    .in_root   (sq_root),
    .in_side   (sq_side),
    .out_valid (dv_valid),
    .out_quo   (dv_quo),
    .out_side  (dv_side)
  );

  // output stage: sign, saturate, place lanes around the half-root component
  logic [rmq_pkg::DATA_W-1:0] lane_val [rmq_pkg::LANES];
  logic [rmq_pkg::LANES-1:0]  lane_sat;
  logic [rmq_pkg::DATA_W-1:0] qx_nxt, qy_nxt, qz_nxt, qw_nxt;
  logic                       flag_nxt;
  logic                       valid_r;
  logic [rmq_pkg::DATA_W-1:0] qx_r, qy_r, qz_r, qw_r;
  logic                       flag_r;

  always_comb begin
    for (int l = 0; l < rmq_pkg::LANES; l++) begin
      lane_sat[l] = 1'b0;
      if (!dv_side.neg[l]) begin
        if (dv_quo[l] > rmq_pkg::POS_LIM) begin
          lane_sat[l] = 1'b1;
          lane_val[l] = rmq_pkg::DATA_W'(rmq_pkg::POS_LIM);
        end else begin
          lane_val[l] = rmq_pkg::DATA_W'(dv_quo[l]);
        end
      end else begin
        if (dv_quo[l] > rmq_pkg::NEG_LIM) begin
          lane_sat[l] = 1'b1;
          lane_val[l] = rmq_pkg::DATA_W'(rmq_pkg::NEG_LIM);
        end else begin
          lane_val[l] = rmq_pkg::DATA_W'(rmq_pkg::QUO_W'(0) - dv_quo[l]);
        end
      end
    end
    unique case (dv_side.sel)
      rmq_pkg::COMP_X: begin
        qx_nxt = dv_side.half; qy_nxt = lane_val[0];
        qz_nxt = lane_val[1];  qw_nxt = lane_val[2];
      end
      rmq_pkg::COMP_Y: begin
        qx_nxt = lane_val[0];  qy_nxt = dv_side.half;
        qz_nxt = lane_val[1];  qw_nxt = lane_val[2];
      end
      rmq_pkg::COMP_Z: begin
        qx_nxt = lane_val[0];  qy_nxt = lane_val[1];
        qz_nxt = dv_side.half; qw_nxt = lane_val[2];
      end
      default: begin
        qx_nxt = lane_val[0];  qy_nxt = lane_val[1];
        qz_nxt = lane_val[2];  qw_nxt = dv_side.half;
      end
    endcase
    // zero root: everything zero, only a clamped argument raises the flag
    if (dv_side.zero) begin
      qx_nxt   = '0;
      qy_nxt   = '0;
      qz_nxt   = '0;
      qw_nxt   = '0;
      flag_nxt = dv_side.neg_arg;
    end else begin
      flag_nxt = dv_side.neg_arg || (|lane_sat);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    qx_r   <= qx_nxt;
    qy_r   <= qy_nxt;
    qz_r   <= qz_nxt;
    qw_r   <= qw_nxt;
    flag_r <= flag_nxt;
  end

  assign out_valid         = valid_r;
  assign out_quat_x        = qx_r;
  assign out_quat_y        = qy_r;
  assign out_quat_z        = qz_r;
  assign out_quat_w        = qw_r;
  assign out_overflow_flag = flag_r;

  // a zero root must come out as the all-zero quaternion
  a_zero_root: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_valid && dv_side.zero) |=>
      (out_valid && out_quat_x == '0 && out_quat_y == '0 &&
       out_quat_z == '0 && out_quat_w == '0))
    else $error("zero root gave a nonzero quaternion");

endmodule
